@@ sv/ppls_pkg.sv @@
`timescale 1ns / 1ps
package ppls_pkg;

  // Fixed formats
  localparam int NORMAL_WIDTH = 24;
  localparam int VEC_FRAC     = 14;
  localparam int SPEC_EXP     = 6;
  localparam int CHAN_MAX     = 255;
  localparam int LDIR_W       = 16;
  localparam int MAG_W        = 32;
  localparam int SH_W         = 5;
  localparam int MSB_TARGET   = 30;
  localparam int Q_W          = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 15;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;

  // Pipeline depths of the back end
  localparam int NORM_LAT = 4 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int PIPE_LAT = NORM_LAT + 6 + SPEC_EXP + 3;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMB_COLOR,
    REG_LIGHT_COLOR,
    REG_LIGHT_DIR,
    REG_VIEW_DIR,
    REG_AMB_K,
    REG_DIF_K,
    REG_SPC_K
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [SH_W-1:0]       sh;
  } vec_cls_t;

  typedef struct packed {
    vec_cls_t n;
    vec_cls_t l;
    logic     degen;
  } front_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic [23:0] amb_color;
    logic [23:0] light_color;
    logic [47:0] view_dir;
    logic [26:0] ka;
    logic [26:0] kd;
    logic [26:0] ks;
  } shade_cfg_t;

  // Magnitudes plus the left shift that brings the largest one to 2^30 or above
  function automatic vec_cls_t classify(input logic [2:0][MAG_W-1:0] mag,
                                        input logic [2:0] neg);
    vec_cls_t        c;
    logic [MAG_W-1:0] mx;
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    c.mag = mag;
    c.neg = neg;
    c.sh  = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i]) c.sh = (i >= MSB_TARGET) ? '0 : SH_W'(MSB_TARGET - i);
    end
    return c;
  endfunction

endpackage

@@ sv/ppls_if.sv @@
`timescale 1ns / 1ps
interface ppls_in_if import ppls_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface ppls_out_if import ppls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       degenerate;
  modport source (output valid, red, green, blue, degenerate, input ready);
  modport sink   (input valid, red, green, blue, degenerate, output ready);
endinterface

@@ sv/ppls_front.sv @@
`timescale 1ns / 1ps
module ppls_front import ppls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ppls_in_if.sink           in_ch,
  input  logic [CFG_W-1:0]  light_dir,
  input  logic              push_ok,
  output logic              push,
  output front_item_t       item
);

  logic                          adv;
  logic                          f1_vld_r;
  logic                          f2_vld_r;
  logic [2:0][MAG_W-1:0]         f1_nmag_r, f1_lmag_r;
  logic [2:0]                    f1_nneg_r, f1_lneg_r;
  front_item_t                   f2_item_r;
  logic [2:0][NORMAL_WIDTH-1:0]  nraw;
  logic [2:0][LDIR_W-1:0]        lraw;
  logic [2:0][MAG_W-1:0]         nmag, lmag;
  logic [2:0]                    nneg, lneg;
  logic [MAG_W-1:0]              next_ext, lext;
  vec_cls_t                      ncls, lcls;

  // Advance the two front stages together
  assign adv         = !f2_vld_r || push_ok;
  assign in_ch.ready = adv;
  assign push        = f2_vld_r && push_ok;
  assign item        = f2_item_r;

  // Split components into sign and magnitude
  always_comb begin
    next_ext = '0;
    lext     = '0;
    nraw[0]  = in_ch.normal_x;
    nraw[1]  = in_ch.normal_y;
    nraw[2]  = in_ch.normal_z;
    for (int i = 0; i < 3; i++) begin
      lraw[i]  = light_dir[CFG_W-1-LDIR_W*i -: LDIR_W];
      next_ext = {{(MAG_W-NORMAL_WIDTH){nraw[i][NORMAL_WIDTH-1]}}, nraw[i]};
      nneg[i]  = nraw[i][NORMAL_WIDTH-1];
      nmag[i]  = nneg[i] ? (~next_ext + MAG_W'(1)) : next_ext;
      lext     = {{(MAG_W-LDIR_W){lraw[i][LDIR_W-1]}}, lraw[i]};
      lneg[i]  = lraw[i][LDIR_W-1];
      lmag[i]  = lneg[i] ? (~lext + MAG_W'(1)) : lext;
    end
  end

  // Find the normalising shift of each vector
  assign ncls = classify(f1_nmag_r, f1_nneg_r);
  assign lcls = classify(f1_lmag_r, f1_lneg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_ch.valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_nmag_r       <= nmag;
      f1_nneg_r       <= nneg;
      f1_lmag_r       <= lmag;
      f1_lneg_r       <= lneg;
      f2_item_r.n     <= ncls;
      f2_item_r.l     <= lcls;
      f2_item_r.degen <= (f1_nmag_r == '0) || (f1_lmag_r == '0);
    end
  end

endmodule

@@ sv/ppls_fifo.sv @@
`timescale 1ns / 1ps
module ppls_fifo import ppls_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  front_item_t  push_item,
  input  logic         pop,
  output logic         pop_vld,
  output front_item_t  pop_item,
  output fifo_status_t status
);

  front_item_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_pop;

  assign status.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_vld      = !status.empty;
  assign pop_item     = mem_r[rp_r];
  assign do_pop       = pop && !status.empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_AW'(1);
      if (do_pop) rp_r <= rp_r + FIFO_AW'(1);
      if (push && !do_pop) cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      else if (do_pop && !push) cnt_r <= cnt_r - (FIFO_AW+1)'(1);
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

@@ sv/ppls_norm.sv @@
`timescale 1ns / 1ps
module ppls_norm import ppls_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  vec_cls_t            vin,
  output logic [2:0][Q_W-1:0] q
);

  localparam int RW = MAG_W + 2;

  logic [2:0][MAG_W-1:0]   s0_mag_r, s1_mag_r;
  logic [2:0]              s0_neg_r, s1_neg_r;
  logic [2:0][2*MAG_W-1:0] s1_sq_r;

  logic [2*MAG_W-1:0]      sq_m_r    [SQRT_STEPS+1];
  logic [2*MAG_W-1:0]      sq_root_r [SQRT_STEPS+1];
  logic [2:0][MAG_W-1:0]   sq_mag_r  [SQRT_STEPS+1];
  logic [2:0]              sq_neg_r  [SQRT_STEPS+1];

  logic [2:0][RW-1:0]        dv_rem_r [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] dv_q_r   [DIV_STEPS+1];
  logic [MAG_W-1:0]          dv_s_r   [DIV_STEPS+1];
  logic [2:0]                dv_neg_r [DIV_STEPS+1];

  logic [2:0][Q_W-1:0]     q_r;

  assign q = q_r;

  // Shift up, square, sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_mag_r[i] <= vin.mag[i] << vin.sh;
        s1_sq_r[i]  <= s0_mag_r[i] * s0_mag_r[i];
      end
      s0_neg_r     <= vin.neg;
      s1_mag_r     <= s0_mag_r;
      s1_neg_r     <= s0_neg_r;
      sq_m_r[0]    <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      sq_root_r[0] <= '0;
      sq_mag_r[0]  <= s1_mag_r;
      sq_neg_r[0]  <= s1_neg_r;
    end
  end

  // Square root, one result bit a stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int BSH = 2 * (SQRT_STEPS - 1 - k);
    logic [2*MAG_W-1:0] bit_v, trial;
    logic               ge;
    always_comb begin
      bit_v = (2*MAG_W)'(1) << BSH;
      trial = sq_root_r[k] + bit_v;
      ge    = sq_m_r[k] >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_m_r[k+1]    <= ge ? sq_m_r[k] - trial : sq_m_r[k];
        sq_root_r[k+1] <= ge ? (sq_root_r[k] >> 1) + bit_v : sq_root_r[k] >> 1;
        sq_mag_r[k+1]  <= sq_mag_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
      end
    end
  end

  // Load the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {2'b00, sq_mag_r[SQRT_STEPS][i]};
        dv_q_r[0][i]   <= '0;
      end
      dv_s_r[0]   <= sq_root_r[SQRT_STEPS][MAG_W-1:0];
      dv_neg_r[0] <= sq_neg_r[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [2:0]         ge;
    logic [2:0][RW-1:0] rem_n;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = dv_rem_r[k][i] >= {2'b00, dv_s_r[k]};
        rem_n[i] = (ge[i] ? dv_rem_r[k][i] - {2'b00, dv_s_r[k]} : dv_rem_r[k][i]) << 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k+1][i] <= rem_n[i];
          dv_q_r[k+1][i]   <= {dv_q_r[k][i][DIV_STEPS-2:0], ge[i]};
        end
        dv_s_r[k+1]   <= dv_s_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
      end
    end
  end

  // Restore the signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= dv_neg_r[DIV_STEPS][i] ? (~{1'b0, dv_q_r[DIV_STEPS][i]} + Q_W'(1))
                                         : {1'b0, dv_q_r[DIV_STEPS][i]};
      end
    end
  end

endmodule

@@ sv/ppls_back.sv @@
`timescale 1ns / 1ps
module ppls_back import ppls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_vld,
  input  front_item_t item,
  output logic        pop,
  input  shade_cfg_t  cfg,
  ppls_out_if.source  out_ch
);

  localparam int DP_W    = 16;
  localparam int R_W     = 20;
  localparam int RVP_W   = R_W + 16;
  localparam int RSUM_W  = RVP_W + 2;
  localparam int RV_W    = RSUM_W - VEC_FRAC;
  localparam int P_W     = 32;
  localparam int PROD_W  = P_W + RV_W;
  localparam int COL_SH  = 8 + VEC_FRAC;
  localparam int SUM_W   = 29;
  localparam logic [P_W-1:0] P_CAP = P_W'(1) << (VEC_FRAC + 17);

  logic                   en;
  logic [PIPE_LAT-1:0]    vld_r, dg_r;
  logic [2:0][Q_W-1:0]    nq, lq;

  logic signed [31:0]     nl_r [3];
  logic signed [Q_W-1:0]  n1_r [3], l1_r [3], n2_r [3], l2_r [3], l3_r [3];
  logic [2:0]             nneg3_r;
  logic [DP_W-1:0]        dp2_r, dp3_r, dp4_r, dp5_r, dp6_r;
  logic [31:0]            tm_r [3];
  logic signed [R_W-1:0]  r4_r [3];
  logic signed [RVP_W-1:0] rvp_r [3];
  logic [RV_W-1:0]        rv6_r;

  logic [PROD_W-1:0]      pw_prod_r [SPEC_EXP];
  logic [RV_W-1:0]        pw_rv_r   [SPEC_EXP];
  logic [DP_W-1:0]        pw_dp_r   [SPEC_EXP];

  logic [P_W-1:0]         p_r;
  logic [DP_W-1:0]        dpc_r;
  logic [16:0]            ld_r [3], ls_r [3];
  logic [8:0]             amb1_r [3], amb2_r [3];
  logic [10:0]            dif_r [3];
  logic [26:0]            spc_r [3];
  logic [7:0]             col_r [3];

  logic signed [33:0]     dsum;
  logic signed [RSUM_W-1:0] rsum;
  logic [DP_W-1:0]        dp_n;
  logic [RV_W-1:0]        rv_n;
  logic signed [R_W-1:0]  ts [3], lext [3];
  logic [15:0]            nmag [3];
  logic [SUM_W-1:0]       csum [3];

  // Clamp one power step at the cap
  function automatic logic [P_W-1:0] cap_p(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] s;
    s = prod >> VEC_FRAC;
    return (s > PROD_W'(P_CAP)) ? P_CAP : s[P_W-1:0];
  endfunction

  // Whole back end advances unless the result waits
  assign en  = !vld_r[PIPE_LAT-1] || out_ch.ready;
  assign pop = en && item_vld;

  ppls_norm u_norm_n (.clk(clk), .en(en), .vin(item.n), .q(nq));
  ppls_norm u_norm_l (.clk(clk), .en(en), .vin(item.l), .q(lq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      dg_r  <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], pop};
      dg_r  <= {dg_r[PIPE_LAT-2:0], item.degen};
    end
  end

  // Dot products and reflection vector
  always_comb begin
    dsum = 34'(nl_r[0]) + 34'(nl_r[1]) + 34'(nl_r[2]);
    dp_n = (dsum > 0) ? dsum[VEC_FRAC +: DP_W] : '0;
    rsum = RSUM_W'(rvp_r[0]) + RSUM_W'(rvp_r[1]) + RSUM_W'(rvp_r[2]);
    rv_n = (rsum > 0) ? rsum[VEC_FRAC +: RV_W] : '0;
    for (int i = 0; i < 3; i++) begin
      nmag[i] = n2_r[i][Q_W-1] ? 16'(-n2_r[i]) : 16'(n2_r[i]);
      ts[i]   = nneg3_r[i] ? -$signed({2'b00, tm_r[i][31:VEC_FRAC]})
                           :  $signed({2'b00, tm_r[i][31:VEC_FRAC]});
      lext[i] = R_W'(l3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1_r[i]    <= $signed(nq[i]);
        l1_r[i]    <= $signed(lq[i]);
        nl_r[i]    <= $signed(nq[i]) * $signed(lq[i]);
        n2_r[i]    <= n1_r[i];
        l2_r[i]    <= l1_r[i];
        tm_r[i]    <= nmag[i] * dp2_r;
        nneg3_r[i] <= n2_r[i][Q_W-1];
        l3_r[i]    <= l2_r[i];
        r4_r[i]    <= (ts[i] <<< 1) - lext[i];
        rvp_r[i]   <= r4_r[i] * $signed(cfg.view_dir[CFG_W-1-16*i -: 16]);
      end
      dp2_r <= dp_n;
      dp3_r <= dp2_r;
      dp4_r <= dp3_r;
      dp5_r <= dp4_r;
      dp6_r <= dp5_r;
      rv6_r <= rv_n;
      pw_prod_r[0] <= PROD_W'(rv6_r) << VEC_FRAC;
      pw_rv_r[0]   <= rv6_r;
      pw_dp_r[0]   <= dp6_r;
    end
  end

  // Raise to the specular exponent, one multiply a stage
  for (genvar e = 1; e < SPEC_EXP; e++) begin : g_pow
    always_ff @(posedge clk) begin
      if (en) begin
        pw_prod_r[e] <= cap_p(pw_prod_r[e-1]) * pw_rv_r[e-1];
        pw_rv_r[e]   <= pw_rv_r[e-1];
        pw_dp_r[e]   <= pw_dp_r[e-1];
      end
    end
  end

  // Colour terms, sum and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = SUM_W'(amb2_r[i]);
      if (!dg_r[PIPE_LAT-2]) csum[i] = csum[i] + SUM_W'(dif_r[i]) + SUM_W'(spc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] ap;
    logic [32:0] dprod;
    logic [48:0] sprod;
    if (en) begin
      p_r   <= cap_p(pw_prod_r[SPEC_EXP-1]);
      dpc_r <= pw_dp_r[SPEC_EXP-1];
      for (int i = 0; i < 3; i++) begin
        ap        = cfg.amb_color[23-8*i -: 8] * cfg.ka[26-9*i -: 9];
        amb1_r[i] <= ap[16:8];
        ld_r[i]   <= cfg.light_color[23-8*i -: 8] * cfg.kd[26-9*i -: 9];
        ls_r[i]   <= cfg.light_color[23-8*i -: 8] * cfg.ks[26-9*i -: 9];
        dprod     = ld_r[i] * dpc_r;
        sprod     = ls_r[i] * p_r;
        dif_r[i]  <= dprod[32:COL_SH];
        spc_r[i]  <= sprod[48:COL_SH];
        amb2_r[i] <= amb1_r[i];
        col_r[i]  <= (csum[i] > SUM_W'(CHAN_MAX)) ? 8'(CHAN_MAX) : csum[i][7:0];
      end
    end
  end

  assign out_ch.valid      = vld_r[PIPE_LAT-1];
  assign out_ch.degenerate = dg_r[PIPE_LAT-1];
  assign out_ch.red        = col_r[0];
  assign out_ch.green      = col_r[1];
  assign out_ch.blue       = col_r[2];

endmodule

@@ sv/phong_point_light_shader.sv @@
`timescale 1ns / 1ps
// Phong shader with one point light.
// in_ch carries one surface normal per beat (signed x, y, z of any scale);
// out_ch returns red, green, blue (clamped at 255) and a degenerate flag
// that is set when the normal or the light vector is zero, in which case
// only the ambient term is kept.
// Configuration is written through cfg_we / cfg_index / cfg_wdata, one
// register per cycle; the user must write only while no beat is in flight,
// which the block does not enforce. Unknown indexes are dropped. Throughput is
// one beat per cycle unless out_ch stalls. A beat passes two front stages, the
// queue, then a 67-stage back end dominated by the 32-stage square root and
// the 15-stage dividers of the two vector normalisers, and the six-stage power
// chain. When out_ch stalls the whole back end holds; the four-entry queue and
// the front stages keep taking beats until full, then in_ch.ready drops. Reset
// (synchronous, rst_n low) empties every stage and the queue and loads the
// register defaults: all zero except the view vector, which is +1.0 in z.
module phong_point_light_shader import ppls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ppls_in_if.sink              in_ch,
  ppls_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  shade_cfg_t   cfg_r;
  logic [47:0]  light_dir_r;
  logic         push, push_ok, fifo_vld, fifo_pop;
  front_item_t  push_item, pop_item;
  fifo_status_t fifo_st;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{amb_color: '0, light_color: '0, view_dir: 48'd16384,
                       ka: '0, kd: '0, ks: '0};
      light_dir_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMB_COLOR:   cfg_r.amb_color   <= cfg_wdata[23:0];
        REG_LIGHT_COLOR: cfg_r.light_color <= cfg_wdata[23:0];
        REG_LIGHT_DIR:   light_dir_r       <= cfg_wdata[47:0];
        REG_VIEW_DIR:    cfg_r.view_dir    <= cfg_wdata[47:0];
        REG_AMB_K:       cfg_r.ka          <= cfg_wdata[26:0];
        REG_DIF_K:       cfg_r.kd          <= cfg_wdata[26:0];
        REG_SPC_K:       cfg_r.ks          <= cfg_wdata[26:0];
        default: ;
      endcase
    end
  end

  assign push_ok = !fifo_st.full;

  ppls_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .light_dir(light_dir_r),
    .push_ok(push_ok), .push(push), .item(push_item)
  );

  ppls_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(fifo_pop), .pop_vld(fifo_vld), .pop_item(pop_item), .status(fifo_st)
  );

  ppls_back u_back (
    .clk(clk), .rst_n(rst_n), .item_vld(fifo_vld), .item(pop_item),
    .pop(fifo_pop), .cfg(cfg_r), .out_ch(out_ch)
  );

  // Queue can never be full and empty at once
  a_fifo_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue reports full and empty together");

  // A waiting result freezes the back end, so nothing leaves the queue
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !fifo_pop)
    else $error("queue popped while the result was stalled");

  // Reset clears the result stage
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid straight after reset");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import ppls_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       degenerate;
  } colour_t;

  typedef struct {
    logic signed [NORMAL_WIDTH-1:0] nx;
    logic signed [NORMAL_WIDTH-1:0] ny;
    logic signed [NORMAL_WIDTH-1:0] nz;
    bit                             known;
    colour_t                        colour;
  } row_t;

  typedef longint vec3_t [3];

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int                   DRAIN_CYCLES   = PIPE_LAT + 40;
  localparam int                   HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ppls_in_if  in_ch ();
  ppls_out_if out_ch ();

  phong_point_light_shader i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the shading registers
  logic [23:0] amb_colour;
  logic [23:0] light_colour;
  logic [47:0] light_dir;
  logic [47:0] view_dir;
  logic [26:0] ka_reg;
  logic [26:0] kd_reg;
  logic [26:0] ks_reg;

  colour_t colour_q[$];
  int      err_count;
  bit      hold_req;
  int      stall_pct;
  int      gap_max;
  int      burst_left;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] m);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q1.14; zero vector gives 0
  function automatic bit to_unit(input vec3_t c, output vec3_t q);
    logic [63:0] mag[3];
    logic [63:0] mx;
    logic [63:0] s;
    bit          neg[3];
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    q = '{0, 0, 0};
    if (mx == 0) return 0;
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    s = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int i = 0; i < 3; i++) begin
      q[i] = longint'((mag[i] << VEC_FRAC) / s);
      if (neg[i]) q[i] = -q[i];
    end
    return 1;
  endfunction

  function automatic colour_t shade(input logic signed [NORMAL_WIDTH-1:0] nx,
                                    input logic signed [NORMAL_WIDTH-1:0] ny,
                                    input logic signed [NORMAL_WIDTH-1:0] nz);
    vec3_t       nraw, lraw, vw, n, l;
    bit          degen;
    longint      dsum, rsum, t, rr;
    logic [63:0] dp, rv, p, mg, sum, ac, lc, ka, kd, ks;
    logic [63:0] cap;
    logic [127:0] prod;
    logic [7:0]  ch[3];
    colour_t     res;
    nraw = '{longint'(nx), longint'(ny), longint'(nz)};
    lraw = '{longint'($signed(light_dir[47:32])), longint'($signed(light_dir[31:16])),
             longint'($signed(light_dir[15:0]))};
    vw   = '{longint'($signed(view_dir[47:32])), longint'($signed(view_dir[31:16])),
             longint'($signed(view_dir[15:0]))};
    degen = !(to_unit(nraw, n) & to_unit(lraw, l));
    dp  = '0;
    rv  = '0;
    p   = 64'd1 << VEC_FRAC;
    cap = 64'd1 << (VEC_FRAC + 17);
    if (!degen) begin
      dsum = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      if (dsum > 0) dp = dsum >> VEC_FRAC;
      rsum = 0;
      for (int i = 0; i < 3; i++) begin
        mg = n[i] < 0 ? -n[i] : n[i];
        t  = longint'((mg * dp) >> VEC_FRAC);
        if (n[i] < 0) t = -t;
        rr   = 2 * t - l[i];
        rsum = rsum + rr * vw[i];
      end
      if (rsum > 0) rv = rsum >> VEC_FRAC;
      // Raise to the specular power, saturating
      for (int e = 0; e < SPEC_EXP; e++) begin
        prod = p * {64'd0, rv};
        if (prod > 128'hFFFF_FFFF_FFFF_FFFF) begin
          p = cap;
        end else begin
          p = prod[63:0] >> VEC_FRAC;
          if (p > cap) p = cap;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      ac  = (amb_colour >> (16 - 8 * i)) & 64'hFF;
      lc  = (light_colour >> (16 - 8 * i)) & 64'hFF;
      ka  = (ka_reg >> (18 - 9 * i)) & 64'h1FF;
      kd  = (kd_reg >> (18 - 9 * i)) & 64'h1FF;
      ks  = (ks_reg >> (18 - 9 * i)) & 64'h1FF;
      sum = (ac * ka) >> 8;
      if (!degen) begin
        sum = sum + ((lc * kd * dp) >> (8 + VEC_FRAC));
        sum = sum + ((lc * ks * p) >> (8 + VEC_FRAC));
      end
      ch[i] = (sum > CHAN_MAX) ? 8'(CHAN_MAX) : sum[7:0];
    end
    res.red        = ch[0];
    res.green      = ch[1];
    res.blue       = ch[2];
    res.degenerate = degen;
    return res;
  endfunction

  // Write one register and mirror it; write enable is lowered by cfg_finish
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_AMB_COLOR:   amb_colour   = val[23:0];
      REG_LIGHT_COLOR: light_colour = val[23:0];
      REG_LIGHT_DIR:   light_dir    = val[47:0];
      REG_VIEW_DIR:    view_dir     = val[47:0];
      REG_AMB_K:       ka_reg       = val[26:0];
      REG_DIF_K:       kd_reg       = val[26:0];
      REG_SPC_K:       ks_reg       = val[26:0];
      default: ;
    endcase
  endtask

  task automatic cfg_finish();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (colour_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one beat and hold it until accepted; gaps only between bursts
  task automatic send_normal(input logic signed [NORMAL_WIDTH-1:0] nx,
                             input logic signed [NORMAL_WIDTH-1:0] ny,
                             input logic signed [NORMAL_WIDTH-1:0] nz,
                             input bit known, input colour_t colour);
    in_ch.valid    <= 1'b1;
    in_ch.normal_x <= nx;
    in_ch.normal_y <= ny;
    in_ch.normal_z <= nz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    colour_q.push_back(known ? colour : shade(nx, ny, nz));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [NORMAL_WIDTH-1:0] rand_comp(input int mode);
    case (mode)
      0:       return NORMAL_WIDTH'($urandom);
      1:       return NORMAL_WIDTH'($signed($urandom_range(0, 64)) - 32);
      2:       return ($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000;
      default: return NORMAL_WIDTH'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    colour_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (colour_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = colour_q.pop_front();
        if (out_ch.red !== want.red)
          report_mismatch($sformatf("red %0d, want %0d", out_ch.red, want.red));
        if (out_ch.green !== want.green)
          report_mismatch($sformatf("green %0d, want %0d", out_ch.green, want.green));
        if (out_ch.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, want %0d", out_ch.blue, want.blue));
        if (out_ch.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %0b, want %0b",
                                    out_ch.degenerate, want.degenerate));
      end
    end
  end

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_t        rows[16];
    colour_t     amb_only, full_on;
    int          mode;
    logic [47:0] v48;
    amb_only = '{8'd128, 8'd64, 8'd32, 1'b0};
    full_on  = '{8'd255, 8'd255, 8'd255, 1'b0};
    rows = '{
      '{24'sd0, 24'sd0, 24'sd1, 1, full_on},
      '{24'sd0, 24'sd0, -24'sd1, 1, amb_only},
      '{24'sd0, 24'sd0, 24'sd0, 1, '{8'd128, 8'd64, 8'd32, 1'b1}},
      '{24'sh7FFFFF, 24'sd0, 24'sd0, 1, amb_only},
      '{24'sh800000, 24'sd0, 24'sd0, 1, amb_only},
      '{24'sd0, 24'sd0, 24'sh7FFFFF, 1, full_on},
      '{24'sd0, 24'sd0, 24'sh800000, 1, amb_only},
      '{24'sd1, 24'sd1, 24'sd1, 0, '0},
      '{-24'sd1, -24'sd1, -24'sd1, 0, '0},
      '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, '0},
      '{24'sh800000, 24'sh800000, 24'sh800000, 0, '0},
      '{24'sh7FFFFF, 24'sh800000, 24'sd1, 0, '0},
      '{24'sd3, -24'sd4, 24'sd5, 0, '0},
      '{24'sd0, 24'sd1, 24'sd0, 0, '0},
      '{-24'sd5, 24'sd0, 24'sd7, 0, '0},
      '{24'sd100, 24'sd200, -24'sd300, 0, '0}
    };

    err_count  = 0;
    hold_req   = 1'b0;
    stall_pct  = 0;
    gap_max    = 0;
    burst_left = 8;
    amb_colour = '0; light_colour = '0; light_dir = '0; view_dir = 48'd16384;
    ka_reg = '0; kd_reg = '0; ks_reg = '0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.normal_x <= '0;
    in_ch.normal_y <= '0;
    in_ch.normal_z <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: light straight down z, unit kd, no specular
    cfg_write(REG_AMB_COLOR, 48'h804020);
    cfg_write(REG_LIGHT_COLOR, 48'hFFFFFF);
    cfg_write(REG_LIGHT_DIR, 48'h1);
    cfg_write(REG_AMB_K, {21'd0, 9'd256, 9'd256, 9'd256});
    cfg_write(REG_DIF_K, {21'd0, 9'd256, 9'd256, 9'd256});
    cfg_write(REG_SPC_K, 48'd0);
    cfg_write(CFG_IDX_UNUSED, {CFG_W{1'b1}});
    cfg_finish();
    foreach (rows[i]) send_normal(rows[i].nx, rows[i].ny, rows[i].nz,
                                  rows[i].known, rows[i].colour);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_AMB_COLOR, 48'hFFFFFF);
          cfg_write(REG_LIGHT_COLOR, 48'hFFFFFF);
          cfg_write(REG_LIGHT_DIR, {CFG_W{1'b1}});
          cfg_write(REG_VIEW_DIR, {CFG_W{1'b1}});
          cfg_write(REG_AMB_K, 48'h7FFFFFF);
          cfg_write(REG_DIF_K, 48'h7FFFFFF);
          cfg_write(REG_SPC_K, 48'h7FFFFFF);
        end
        1: begin
          // Zero light vector: every beat comes back degenerate
          cfg_write(REG_LIGHT_DIR, 48'd0);
          cfg_write(REG_VIEW_DIR, 48'd0);
          cfg_write(REG_AMB_K, 48'd0);
        end
        2: begin
          cfg_write(REG_LIGHT_DIR, {16'sh7FFF, 16'sh8000, 16'sh7FFF});
          cfg_write(REG_VIEW_DIR, {16'sh8000, 16'sh7FFF, 16'sh8000});
          cfg_write(REG_AMB_COLOR, 48'd0);
          cfg_write(REG_LIGHT_COLOR, 48'd0);
        end
        default: begin
          cfg_write(REG_AMB_COLOR, 48'($urandom));
          cfg_write(REG_LIGHT_COLOR, 48'($urandom));
          v48 = 48'({$urandom, $urandom});
          cfg_write(REG_LIGHT_DIR, v48);
          // Mostly a view vector near unit length so specular lands in range
          v48 = {16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384)};
          cfg_write(REG_VIEW_DIR, (ph == 6) ? 48'({$urandom, $urandom}) : v48);
          cfg_write(REG_AMB_K, 48'($urandom));
          cfg_write(REG_DIF_K, 48'($urandom));
          cfg_write(REG_SPC_K, 48'($urandom));
        end
      endcase
      cfg_finish();

      stall_pct = (ph == 4) ? 0 : $urandom_range(0, 60);
      gap_max   = (ph == 4) ? 0 : $urandom_range(1, 12);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < 180; k++) begin
        mode = $urandom_range(0, 9);
        if (k == 90 && ph == 5) begin
          // Pause until every result is back
          in_ch.valid <= 1'b0;
          while (colour_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        if (mode == 9)
          send_normal('0, '0, '0, 0, '0);
        else
          send_normal(rand_comp(mode % 4), rand_comp(mode % 4), rand_comp(mode % 4), 0, '0);
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
